// ===== hdl/lpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, controller state type and controller-to-datapath command.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;

    // fixed port widths
    localparam int PAGE_IN_W = 16;
    localparam int CFG_W     = 4;
    localparam int FIDX_W    = 3;
    localparam int FAULT_W   = 16;

    // derived internal widths
    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam logic [RANK_W-1:0]  RANK_TOP    = RANK_W'(MAX_FRAMES - 1);
    localparam logic [FAULT_W-1:0] FAULT_MAX   = '1;
    localparam logic [CFG_W-1:0]   FRAMES_RST  = CFG_W'(8);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } t_lpr_state;

    typedef struct packed {
        logic lookup;
        logic update;
    } t_lpr_cmd;

endpackage

// ===== hdl/lpr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement controller
// Two-state sequencer: lookup on the accepting edge, then the update state.
// ----------------------------------------------------------------------------
module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    output t_lpr_cmd o_cmd
);

    t_lpr_state r_state;
    t_lpr_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy       = 1'b0;
        o_cmd.lookup = 1'b0;
        o_cmd.update = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.lookup = i_start;
            end
            ST_UPDATE: begin
                o_busy       = 1'b1;
                o_cmd.update = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/lpr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement datapath
// Frame tags, valid bits, age ranks, fault counter and result registers.
// ----------------------------------------------------------------------------
module lpr_datapath
    import lpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lpr_cmd             i_cmd,
    input  logic [PAGE_IN_W-1:0] i_page_number,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_frames_in_use,
    output logic                 o_strobe,
    output logic                 o_hit,
    output logic [FIDX_W-1:0]    o_frame_index,
    output logic [FAULT_W-1:0]   o_fault_count
);

    logic [PAGE_BITS-1:0] r_frame_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [RANK_W-1:0]    r_rank [MAX_FRAMES];
    logic [FAULT_W-1:0]   r_fault;
    logic [CFG_W-1:0]     r_frames_in_use;

    // lookup results held for the update cycle
    logic                 r_hit;
    logic [IDX_W-1:0]     r_sel;
    logic [CNT_W-1:0]     r_limit;
    logic [PAGE_BITS-1:0] r_page;

    logic                 r_strobe;
    logic                 r_out_hit;
    logic [FIDX_W-1:0]    r_out_idx;
    logic [FAULT_W-1:0]   r_out_fault;

    logic [CMP_W-1:0]      w_active_n;
    logic [MAX_FRAMES-1:0] w_active;
    logic [PAGE_BITS-1:0]  w_page;
    logic [MAX_FRAMES-1:0] w_match;
    logic [MAX_FRAMES-1:0] w_empty;
    logic [IDX_W-1:0]      w_hit_idx;
    logic [IDX_W-1:0]      w_empty_idx;
    logic [IDX_W-1:0]      w_vic_idx;
    logic [RANK_W-1:0]     w_best;
    logic                  n_hit;
    logic [IDX_W-1:0]      n_sel;
    logic [CNT_W-1:0]      n_limit;
    logic [RANK_W-1:0]     n_rank [MAX_FRAMES];
    logic [FAULT_W-1:0]    n_fault;

    // clamp the register into 1..MAX_FRAMES
    always_comb begin
        if (r_frames_in_use == '0) begin
            w_active_n = CMP_W'(1);
        end else if (CMP_W'(r_frames_in_use) > CMP_W'(MAX_FRAMES)) begin
            w_active_n = CMP_W'(MAX_FRAMES);
        end else begin
            w_active_n = CMP_W'(r_frames_in_use);
        end
        for (int k = 0; k < MAX_FRAMES; k++) begin
            w_active[k] = CMP_W'(k) < w_active_n;
        end
    end

    assign w_page = PAGE_BITS'(i_page_number);

    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            w_match[k] = w_active[k] && r_valid[k] && (r_frame_page[k] == w_page);
            w_empty[k] = w_active[k] && !r_valid[k];
        end
        // lowest index wins: scan downwards
        w_hit_idx   = '0;
        w_empty_idx = '0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_hit_idx = IDX_W'(k);
            end
            if (w_empty[k]) begin
                w_empty_idx = IDX_W'(k);
            end
        end
        // oldest active frame, lowest index on ties
        w_best    = '0;
        w_vic_idx = '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (w_active[k] && (r_rank[k] > w_best)) begin
                w_best    = r_rank[k];
                w_vic_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        n_hit = |w_match;
        priority if (n_hit) begin
            n_sel   = w_hit_idx;
            n_limit = CNT_W'(r_rank[w_hit_idx]);
        end else if (|w_empty) begin
            n_sel   = w_empty_idx;
            n_limit = CNT_W'(MAX_FRAMES);
        end else begin
            n_sel   = w_vic_idx;
            n_limit = CNT_W'(r_rank[w_vic_idx]);
        end
    end

    // age frames younger than the limit, make the selected frame youngest
    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            n_rank[k] = r_rank[k];
            if (IDX_W'(k) == r_sel) begin
                n_rank[k] = '0;
            end else if (w_active[k] && r_valid[k] && (CNT_W'(r_rank[k]) < r_limit)
                         && (r_rank[k] < RANK_TOP)) begin
                n_rank[k] = r_rank[k] + RANK_W'(1);
            end
        end
        n_fault = r_fault;
        if (!r_hit && (r_fault != FAULT_MAX)) begin
            n_fault = r_fault + FAULT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= '0;
            r_fault         <= '0;
            r_frames_in_use <= FRAMES_RST;
            r_strobe        <= 1'b0;
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_rank[k] <= '0;
            end
        end else begin
            r_strobe <= i_cmd.update;
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_frames_in_use;
            end
            if (i_cmd.update) begin
                for (int k = 0; k < MAX_FRAMES; k++) begin
                    r_rank[k] <= n_rank[k];
                end
                r_fault <= n_fault;
                if (!r_hit) begin
                    r_valid[r_sel] <= 1'b1;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit   <= n_hit;
            r_sel   <= n_sel;
            r_limit <= n_limit;
            r_page  <= w_page;
        end
        if (i_cmd.update) begin
            if (!r_hit) begin
                r_frame_page[r_sel] <= r_page;
            end
            r_out_hit   <= r_hit;
            r_out_idx   <= FIDX_W'(r_sel);
            r_out_fault <= n_fault;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_hit         = r_out_hit;
    assign o_frame_index = r_out_idx;
    assign o_fault_count = r_out_fault;

endmodule

// ===== hdl/lru_page_replacement_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement, fully associative
// Eight page frames with least-recently-used replacement and fault count.
// ----------------------------------------------------------------------------
// Usage:
//   Reference channel: drive i_page_number and raise start; the transfer
//   happens at a rising edge where start is high and busy is low. The tag
//   compare, empty-frame search and victim pick run on that edge.
//   busy is then high for one update cycle, in which ranks, tags and the
//   fault counter are written.
//   Result: o_strobe is high for one cycle, registered from the update
//   state, with o_hit, o_frame_index and o_fault_count. The receiver cannot
//   stall; a result is taken at the edge that ends its strobe cycle.
//   A new reference is not taken during the update cycle, while busy is
//   high; it may be accepted in the cycle its predecessor's result is shown.
//   Configuration: i_cfg_frames_in_use is written when i_cfg_valid and
//   o_cfg_ready are high; o_cfg_ready is always high. Write only while idle.
//   Reset: synchronous, active low; empties all frames, clears ranks and the
//   fault count and sets frames in use to eight.
// ----------------------------------------------------------------------------
module lru_page_replacement_top
    import lpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [PAGE_IN_W-1:0] i_page_number,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_frames_in_use,
    output logic                 o_strobe,
    output logic                 o_hit,
    output logic [FIDX_W-1:0]    o_frame_index,
    output logic [FAULT_W-1:0]   o_fault_count
);

    t_lpr_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    lpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    lpr_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_page_number       (i_page_number),
        .i_cfg_we            (i_cfg_valid),
        .i_cfg_frames_in_use (i_cfg_frames_in_use),
        .o_strobe            (o_strobe),
        .o_hit               (o_hit),
        .o_frame_index       (o_frame_index),
        .o_fault_count       (o_fault_count)
    );

endmodule

// ===== hdl/lpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement port checker
// Timing checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module lpr_checker
    import lpr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input logic               o_hit,
    input logic [FAULT_W-1:0] o_fault_count
);

    // an accepted reference makes the block busy for exactly one cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted reference did not raise busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held beyond the update cycle");

    // the update cycle is followed by the result strobe
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe)
        else $error("result strobe missing after update");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results closer than two cycles");

    // a fault on an unsaturated count can never report zero faults
    a_fault_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> (o_fault_count != '0))
        else $error("fault reported with zero fault count");

endmodule

bind lru_page_replacement_top lpr_checker u_lpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_hit         (o_hit),
    .o_fault_count (o_fault_count)
);
